// File: src/gfl_pkg.sv
// Shared types and constants for the growing free-list id allocator.
// Used by growing_free_list_id_allocator and its testbench; no dependencies.
package gfl_pkg;

  localparam int ID_W  = 14;
  localparam int CNT_W = 15;
  localparam int SUM_W = CNT_W + 1;

  localparam int MAX_IDS     = 16384;
  localparam int FIRST_CHUNK = 4048;
  localparam int NEXT_CHUNK  = 1024;

  localparam logic [1:0] OP_ALLOC      = 2'd0;
  localparam logic [1:0] OP_FREE       = 2'd1;
  localparam logic [1:0] OP_CLEAR_FLAG = 2'd2;
  localparam logic [1:0] OP_RESET      = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [ID_W-1:0] slot_id;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  granted_id;
    logic [1:0]       status;
    logic [CNT_W-1:0] capacity;
    logic             grew_flag;
  } result_t;

endpackage

// File: src/growing_free_list_id_allocator.sv
// Growing free-list id allocator top level: sequencer, counters, result register.
// Depends on gfl_pkg and gfl_ram (free stack and per-id free bits).
// The accepting edge registers the command and starts both RAM reads; the execute state
// then registers the result word and raises done; busy blocks new commands until then.
// Reset: rst clears counters, flag and control; memories are not swept, no wait after reset.
// Receiver cannot stall; done is high for one cycle, result holds to the next execute.
module growing_free_list_id_allocator (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gfl_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output gfl_pkg::result_t result
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                       state;
  logic [1:0]                   op_q;
  logic [gfl_pkg::ID_W-1:0]     slot_q;
  logic [gfl_pkg::CNT_W-1:0]    stack_count, stack_count_next;
  logic [gfl_pkg::CNT_W-1:0]    grown_count, grown_count_next;
  logic [gfl_pkg::CNT_W-1:0]    fresh_next, fresh_next_next;
  logic                         sticky_grew, sticky_grew_next;

  logic                         accept;
  logic                         exec;
  logic [gfl_pkg::CNT_W-1:0]    stack_top;
  logic                         stk_we;
  logic [gfl_pkg::ID_W-1:0]     stk_rdata;
  logic                         bit_we;
  logic [gfl_pkg::ID_W-1:0]     bit_waddr;
  logic                         bit_rdata;
  logic [gfl_pkg::SUM_W-1:0]    chunk;
  logic [gfl_pkg::SUM_W-1:0]    grown_sum;
  logic                         need_grow;
  logic [gfl_pkg::ID_W-1:0]     id;
  logic [1:0]                   status_c;
  logic [gfl_pkg::ID_W-1:0]     granted_c;

  localparam logic [gfl_pkg::SUM_W-1:0] MaxIds =
    gfl_pkg::SUM_W'(gfl_pkg::MAX_IDS);

  assign busy      = (state == S_EXEC);
  assign accept    = start && !busy;
  assign exec      = (state == S_EXEC);
  assign stack_top = stack_count - gfl_pkg::CNT_W'(1);

  gfl_ram #(.WIDTH(gfl_pkg::ID_W), .DEPTH(gfl_pkg::MAX_IDS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stack_count[gfl_pkg::ID_W-1:0]),
    .wdata (slot_q),
    .re    (accept),
    .raddr (stack_top[gfl_pkg::ID_W-1:0]),
    .rdata (stk_rdata)
  );

  gfl_ram #(.WIDTH(1), .DEPTH(gfl_pkg::MAX_IDS)) u_bit_ram (
    .clk   (clk),
    .we    (bit_we),
    .waddr (bit_waddr),
    .wdata (op_q == gfl_pkg::OP_FREE),
    .re    (accept),
    .raddr (cmd.slot_id),
    .rdata (bit_rdata)
  );

  always_comb begin
    stack_count_next = stack_count;
    grown_count_next = grown_count;
    fresh_next_next  = fresh_next;
    sticky_grew_next = sticky_grew;
    stk_we           = 1'b0;
    bit_we           = 1'b0;
    bit_waddr        = slot_q;
    status_c         = gfl_pkg::ST_OK;
    granted_c        = '0;
    id               = fresh_next[gfl_pkg::ID_W-1:0];
    chunk            = (grown_count == '0) ? gfl_pkg::SUM_W'(gfl_pkg::FIRST_CHUNK)
                                           : gfl_pkg::SUM_W'(gfl_pkg::NEXT_CHUNK);
    grown_sum        = {1'b0, grown_count} + chunk;
    need_grow        = (fresh_next >= grown_count);
    unique case (op_q)
      gfl_pkg::OP_ALLOC: begin
        if (stack_count != '0) begin
          stack_count_next = stack_top;
          id               = stk_rdata;
          bit_we           = exec;
          bit_waddr        = id;
          granted_c        = id;
        end else if (need_grow && (grown_sum > MaxIds)) begin
          status_c = gfl_pkg::ST_FULL;
        end else begin
          if (need_grow) begin
            grown_count_next = grown_sum[gfl_pkg::CNT_W-1:0];
            sticky_grew_next = 1'b1;
          end
          fresh_next_next = fresh_next + gfl_pkg::CNT_W'(1);
          bit_we          = exec;
          bit_waddr       = id;
          granted_c       = id;
        end
      end
      gfl_pkg::OP_FREE: begin
        if ({1'b0, slot_q} >= grown_count) begin
          status_c = gfl_pkg::ST_RANGE;
        end else if (({1'b0, slot_q} >= fresh_next) || bit_rdata ||
                     ({1'b0, stack_count} >= MaxIds)) begin
          status_c = gfl_pkg::ST_FREE;
        end else begin
          bit_we           = exec;
          stk_we           = exec;
          stack_count_next = stack_count + gfl_pkg::CNT_W'(1);
        end
      end
      gfl_pkg::OP_CLEAR_FLAG: begin
        sticky_grew_next = 1'b0;
      end
      gfl_pkg::OP_RESET: begin
        stack_count_next = '0;
        grown_count_next = '0;
        fresh_next_next  = '0;
        sticky_grew_next = 1'b0;
      end
      default: begin
        status_c = gfl_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      stack_count <= '0;
      grown_count <= '0;
      fresh_next  <= '0;
      sticky_grew <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q   <= cmd.opcode;
            slot_q <= cmd.slot_id;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          stack_count       <= stack_count_next;
          grown_count       <= grown_count_next;
          fresh_next        <= fresh_next_next;
          sticky_grew       <= sticky_grew_next;
          result.granted_id <= granted_c;
          result.status     <= status_c;
          result.capacity   <= grown_count_next;
          result.grew_flag  <= sticky_grew_next;
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an execute cycle");

  a_stack_le_fresh: assert property (@(posedge clk) disable iff (rst)
    stack_count <= fresh_next)
    else $error("free stack holds more ids than were handed out");

  a_fresh_le_grown: assert property (@(posedge clk) disable iff (rst)
    fresh_next <= grown_count)
    else $error("fresh pointer passed capacity");

  a_grown_le_max: assert property (@(posedge clk) disable iff (rst)
    {1'b0, grown_count} <= MaxIds)
    else $error("capacity beyond maximum id count");

  a_full_no_id: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == gfl_pkg::ST_FULL)) |-> (result.granted_id == '0))
    else $error("refused allocate returned an id");

endmodule

// File: src/gfl_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Generic; no package dependencies.
module gfl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sim/tb_growing_free_list_id_allocator.sv
// Testbench for growing_free_list_id_allocator: directed, bulk-allocate and random traffic.
// Predicts each result word from its own copy of the allocator state and checks it on done.
// Depends on gfl_pkg and the allocator RTL only.
module tb_growing_free_list_id_allocator;

  localparam int STALL_LIMIT = 1000;
  localparam int BULK_ALLOCS = 200;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  gfl_pkg::cmd_t    cmd = '0;
  logic             busy;
  logic             done;
  gfl_pkg::result_t result;

  growing_free_list_id_allocator u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [gfl_pkg::ID_W-1:0] pool_stack [gfl_pkg::MAX_IDS];
  bit                       pool_free [gfl_pkg::MAX_IDS];
  int unsigned              pool_depth;
  int unsigned              pool_capacity;
  int unsigned              pool_fresh;
  bit                       pool_grew;

  gfl_pkg::result_t awaited_results [$];
  int unsigned      held_ids [$];
  int               mismatch_count = 0;
  int               idle_pct = 0;
  int               stall_cycles = 0;
  gfl_pkg::result_t due;

  function automatic void clear_pool();
    pool_depth    = 0;
    pool_capacity = 0;
    pool_fresh    = 0;
    pool_grew     = 1'b0;
  endfunction

  function automatic gfl_pkg::result_t apply_id_op(input gfl_pkg::cmd_t w);
    gfl_pkg::result_t r;
    int unsigned      id;
    int unsigned      chunk;
    r  = '0;
    id = 0;
    case (w.opcode)
      gfl_pkg::OP_ALLOC: begin
        if (pool_depth != 0) begin
          pool_depth--;
          id = pool_stack[pool_depth];
        end else if (pool_fresh < pool_capacity) begin
          id = pool_fresh;
          pool_fresh++;
        end else begin
          chunk = (pool_capacity == 0) ? gfl_pkg::FIRST_CHUNK : gfl_pkg::NEXT_CHUNK;
          if (pool_capacity + chunk > gfl_pkg::MAX_IDS) begin
            r.status = gfl_pkg::ST_FULL;
          end else begin
            pool_capacity += chunk;
            pool_grew = 1'b1;
            id = pool_fresh;
            pool_fresh++;
          end
        end
        if (r.status == gfl_pkg::ST_OK) begin
          pool_free[id] = 1'b0;
          r.granted_id  = id[gfl_pkg::ID_W-1:0];
        end
      end
      gfl_pkg::OP_FREE: begin
        id = w.slot_id;
        if (id >= pool_capacity) begin
          r.status = gfl_pkg::ST_RANGE;
        end else if (id >= pool_fresh || pool_free[id] || pool_depth >= gfl_pkg::MAX_IDS) begin
          r.status = gfl_pkg::ST_FREE;
        end else begin
          pool_free[id] = 1'b1;
          pool_stack[pool_depth] = id[gfl_pkg::ID_W-1:0];
          pool_depth++;
        end
      end
      gfl_pkg::OP_CLEAR_FLAG: begin
        pool_grew = 1'b0;
      end
      default: begin
        clear_pool();
      end
    endcase
    r.capacity  = pool_capacity[gfl_pkg::CNT_W-1:0];
    r.grew_flag = pool_grew;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < 50)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result word", result, 0);
      end else begin
        due = awaited_results.pop_front();
        if (result.granted_id !== due.granted_id)
          report_mismatch("granted_id", result.granted_id, due.granted_id);
        if (result.status !== due.status)
          report_mismatch("status", result.status, due.status);
        if (result.capacity !== due.capacity)
          report_mismatch("capacity", result.capacity, due.capacity);
        if (result.grew_flag !== due.grew_flag)
          report_mismatch("grew_flag", result.grew_flag, due.grew_flag);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results pending", $time, awaited_results.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // hold start low for a random burst
  task automatic idle_gap();
    logic [15:0] noise;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      noise = 16'($urandom);
      start <= 1'b0;
      cmd   <= noise;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_word(input logic [1:0] op, input logic [gfl_pkg::ID_W-1:0] slot,
                           output gfl_pkg::result_t outcome);
    gfl_pkg::cmd_t w;
    int            idx [$];
    w.opcode  = op;
    w.slot_id = slot;
    cmd   <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    outcome = apply_id_op(w);
    awaited_results = {awaited_results, outcome};
    if (op == gfl_pkg::OP_ALLOC && outcome.status == gfl_pkg::ST_OK) begin
      held_ids = {held_ids, int'(outcome.granted_id)};
    end else if (op == gfl_pkg::OP_FREE && outcome.status == gfl_pkg::ST_OK) begin
      idx = held_ids.find_first_index(x) with (x == slot);
      if (idx.size() != 0) held_ids.delete(idx[0]);
    end else if (op == gfl_pkg::OP_RESET) begin
      held_ids.delete();
    end
  endtask

  task automatic test_directed_cases();
    gfl_pkg::result_t r;
    idle_pct = 30;
    send_word(gfl_pkg::OP_FREE,       14'd0,     r);
    send_word(gfl_pkg::OP_ALLOC,      14'h3FFF,  r);
    send_word(gfl_pkg::OP_ALLOC,      14'd0,     r);
    send_word(gfl_pkg::OP_ALLOC,      14'd5,     r);
    send_word(gfl_pkg::OP_FREE,       14'd1,     r);
    send_word(gfl_pkg::OP_FREE,       14'd1,     r);
    send_word(gfl_pkg::OP_FREE,       14'd3,     r);
    send_word(gfl_pkg::OP_FREE,       14'd4047,  r);
    send_word(gfl_pkg::OP_FREE,       14'd4048,  r);
    send_word(gfl_pkg::OP_FREE,       14'h3FFF,  r);
    send_word(gfl_pkg::OP_ALLOC,      14'd0,     r);
    send_word(gfl_pkg::OP_CLEAR_FLAG, 14'h3FFF,  r);
    send_word(gfl_pkg::OP_ALLOC,      14'h2AAA,  r);
    send_word(gfl_pkg::OP_FREE,       14'd0,     r);
    send_word(gfl_pkg::OP_FREE,       14'd2,     r);
    send_word(gfl_pkg::OP_ALLOC,      14'h1555,  r);
    send_word(gfl_pkg::OP_ALLOC,      14'd0,     r);
    send_word(gfl_pkg::OP_RESET,      14'h3FFF,  r);
    send_word(gfl_pkg::OP_FREE,       14'd0,     r);
    send_word(gfl_pkg::OP_ALLOC,      14'd0,     r);
    send_word(gfl_pkg::OP_CLEAR_FLAG, 14'd0,     r);
    send_word(gfl_pkg::OP_RESET,      14'd0,     r);
  endtask

  task automatic test_bulk_alloc();
    gfl_pkg::result_t r;
    int               guard;
    idle_pct = 10;
    guard    = 0;
    send_word(gfl_pkg::OP_RESET, 14'd0, r);
    do begin
      idle_gap();
      send_word(gfl_pkg::OP_ALLOC, 14'($urandom), r);
      guard++;
    end while (r.status == gfl_pkg::ST_OK && guard < BULK_ALLOCS);
    send_word(gfl_pkg::OP_ALLOC, 14'h3FFF, r);
    send_word(gfl_pkg::OP_FREE, 14'(held_ids[$]), r);
    send_word(gfl_pkg::OP_ALLOC, 14'd0, r);
    send_word(gfl_pkg::OP_ALLOC, 14'd0, r);
    send_word(gfl_pkg::OP_FREE, 14'(pool_capacity), r);
    send_word(gfl_pkg::OP_FREE, 14'h3FFF, r);
    send_word(gfl_pkg::OP_FREE, 14'(held_ids[0]), r);
    send_word(gfl_pkg::OP_FREE, 14'd0, r);
    send_word(gfl_pkg::OP_CLEAR_FLAG, 14'd0, r);
  endtask

  task automatic test_random_traffic(input int n_items, input bit allow_idle);
    gfl_pkg::result_t         r;
    int                       roll;
    int                       alloc_pct;
    int                       free_pct;
    int unsigned              pick;
    logic [gfl_pkg::ID_W-1:0] slot;
    alloc_pct = 45;
    free_pct  = 45;
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: begin alloc_pct = 70; free_pct = 20; end
          1: begin alloc_pct = 20; free_pct = 70; end
          default: begin alloc_pct = 45; free_pct = 45; end
        endcase
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 25;
          default: idle_pct = 50;
        endcase
        if (!allow_idle) idle_pct = 0;
      end
      idle_gap();
      roll = $urandom_range(0, 199);
      slot = 14'($urandom);
      if (roll < 2 * alloc_pct ||
          (roll < 2 * (alloc_pct + free_pct) && held_ids.size() == 0)) begin
        send_word(gfl_pkg::OP_ALLOC, slot, r);
      end else if (roll < 2 * (alloc_pct + free_pct)) begin
        pick = $urandom_range(0, held_ids.size() - 1);
        send_word(gfl_pkg::OP_FREE, 14'(held_ids[pick]), r);
      end else if (roll < 193) begin
        if ($urandom_range(0, 1) == 0 && pool_fresh != 0)
          slot = 14'($urandom_range(0, pool_fresh - 1));
        else if ($urandom_range(0, 1) == 0)
          slot = 14'(pool_capacity + $urandom_range(0, 2) - 1);
        send_word(gfl_pkg::OP_FREE, slot, r);
      end else if (roll < 199) begin
        send_word(gfl_pkg::OP_CLEAR_FLAG, slot, r);
      end else begin
        send_word(gfl_pkg::OP_RESET, slot, r);
      end
    end
  endtask

  initial begin
    clear_pool();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_bulk_alloc();
    test_random_traffic(1370, 1'b1);
    test_random_traffic(250, 1'b0);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: growing_free_list_id_allocator.f
src/gfl_pkg.sv
src/gfl_ram.sv
src/growing_free_list_id_allocator.sv
sim/tb_growing_free_list_id_allocator.sv
